// ----- rtl/weighted_prefix_budget_tree_top_defines.svh -----
`ifndef WEIGHTED_PREFIX_BUDGET_TREE_TOP_DEFINES_SVH
`define WEIGHTED_PREFIX_BUDGET_TREE_TOP_DEFINES_SVH

// A concurrent assertion sampled on clk and switched off while reset is held.
`define WPBT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The same check, required only in the cycles in which the given condition holds.
`define WPBT_ASSERT_ON(label, cond, prop, msg) \
	`WPBT_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ----- rtl/wpbt_pkg.sv -----
`timescale 1ns / 1ps

package wpbt_pkg;

	localparam int LEAF_COUNT  = 1024;
	localparam int WEIGHT_BITS = 32;

	localparam int LEVELS = $clog2(LEAF_COUNT);
	localparam int LEAVES = 1 << LEVELS;
	localparam int NODE_W = LEVELS + 1;
	localparam int NODES  = 2 * LEAVES;
	localparam int STEP_W = $clog2(LEVELS + 1);

	localparam int LEAF_W   = 10;
	localparam int ITEM_W   = 32;
	localparam int SUM_W    = 48;
	localparam int CNT_W    = 24;
	localparam int WIN_BITS = (WEIGHT_BITS > 32) ? 32 : WEIGHT_BITS;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [SUM_W-1:0] weight;
		logic [CNT_W-1:0] items;
	} node_t;

	localparam int WORD_W = $bits(node_t);

endpackage

// ----- rtl/wpbt_ram.sv -----
`timescale 1ns / 1ps

module wpbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/weighted_prefix_budget_tree_top.sv -----
`timescale 1ns / 1ps

// Weighted prefix budget tree: a binary tree in one node memory keeps the saturated weight and
// item count below every node. An add transaction (operation 0) walks from its leaf to the root,
// one node per cycle, reading each parent while it writes the updated node back, and gives no
// result. A query transaction (operation 1) descends from the root, one memory read and one
// compare-subtract per level, plus a leaf step; its result is registered, and the next
// transaction can be taken in the cycle in which that result becomes valid. The block takes one
// transaction at a time, but a finished result waits in the output register while the next one
// runs; a query that ends while that result is still stalled holds its last step. After reset
// the node memory is cleared, one node per cycle, and then transactions are taken.

`include "weighted_prefix_budget_tree_top_defines.svh"

module weighted_prefix_budget_tree_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           operation,
	input  logic [wpbt_pkg::LEAF_W-1:0]    leaf_index,
	input  logic [wpbt_pkg::ITEM_W-1:0]    item_weight,
	input  logic [wpbt_pkg::SUM_W-1:0]     budget,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [wpbt_pkg::CNT_W-1:0]     fit_count,
	output logic [wpbt_pkg::SUM_W-1:0]     fit_weight
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_QUERY = 2'd3;

	localparam int NW = wpbt_pkg::NODE_W;
	localparam int SW = wpbt_pkg::SUM_W;
	localparam int CW = wpbt_pkg::CNT_W;

	localparam logic [NW-1:0] ROOT_NODE  = NW'(1);
	localparam logic [NW-1:0] FIRST_READ = NW'(2);

	logic [1:0]                        state_q;
	logic [NW-1:0]                     addr_q;
	logic [NW-1:0]                     clr_q;
	logic [wpbt_pkg::STEP_W-1:0]       step_q;
	logic [SW-1:0]                     left_q;
	logic [SW-1:0]                     budget_q;
	logic [CW-1:0]                     cnt_q;
	logic [wpbt_pkg::WIN_BITS-1:0]     wadd_q;
	logic                              rsp_valid_q;
	logic [CW-1:0]                     fit_count_q;
	logic [SW-1:0]                     fit_weight_q;

	logic                              accept;
	logic                              leaf_ok;
	logic [NW-1:0]                     leaf_node;
	logic                              ram_wr_en;
	logic [NW-1:0]                     ram_wr_addr;
	logic [wpbt_pkg::WORD_W-1:0]       ram_wr_data;
	logic                              ram_rd_en;
	logic [NW-1:0]                     ram_rd_addr;
	logic [wpbt_pkg::WORD_W-1:0]       ram_rd_data;
	wpbt_pkg::node_t                   rd_node;
	wpbt_pkg::node_t                   upd_node;
	logic [SW:0]                       add_w_sum;
	logic [CW:0]                       add_c_sum;
	logic                              take;
	logic [CW:0]                       q_c_sum;
	logic [CW-1:0]                     cnt_next;
	logic [SW-1:0]                     left_next;
	logic [NW-1:0]                     next_k;
	logic [NW-1:0]                     next_addr;
	logic                              last_step;
	logic                              finish_ok;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign leaf_ok    = 32'(leaf_index) < 32'(wpbt_pkg::LEAF_COUNT);
	assign leaf_node  = NW'(32'(wpbt_pkg::LEAVES) + 32'(leaf_index));

	assign rd_node = wpbt_pkg::node_t'(ram_rd_data);

	// Node totals stay at min(true sum, maximum), so adding along the path is exact.
	assign add_w_sum = {1'b0, rd_node.weight} + (SW + 1)'(wadd_q);
	assign add_c_sum = {1'b0, rd_node.items} + (CW + 1)'(1);
	assign upd_node.weight = add_w_sum[SW] ? wpbt_pkg::SUM_MAX : add_w_sum[SW-1:0];
	assign upd_node.items  = add_c_sum[CW] ? wpbt_pkg::CNT_MAX : add_c_sum[CW-1:0];

	assign take      = left_q >= rd_node.weight;
	assign q_c_sum   = {1'b0, cnt_q} + {1'b0, rd_node.items};
	assign cnt_next  = !take ? cnt_q : (q_c_sum[CW] ? wpbt_pkg::CNT_MAX : q_c_sum[CW-1:0]);
	assign left_next = take ? (left_q - rd_node.weight) : left_q;
	assign next_k    = {addr_q[NW-1:1], take};
	assign last_step = (step_q == wpbt_pkg::STEP_W'(wpbt_pkg::LEVELS));
	assign next_addr = (32'(step_q) + 32'd1 < 32'(wpbt_pkg::LEVELS)) ?
		{next_k[NW-2:0], 1'b0} : next_k;
	assign finish_ok = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = addr_q;
		ram_wr_data = upd_node;
		ram_rd_en   = 1'b0;
		ram_rd_addr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
				ram_wr_data = '0;
			end
			ST_IDLE: begin
				ram_rd_en   = accept;
				ram_rd_addr = operation ? FIRST_READ : leaf_node;
			end
			ST_ADD: begin
				ram_wr_en   = 1'b1;
				ram_rd_en   = 1'b1;
				ram_rd_addr = addr_q >> 1;
			end
			ST_QUERY: begin
				ram_rd_en   = !last_step;
				ram_rd_addr = next_addr;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	wpbt_ram #(
		.WIDTH(wpbt_pkg::WORD_W),
		.DEPTH(wpbt_pkg::NODES)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			addr_q      <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == {NW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && operation) begin
						state_q <= ST_QUERY;
						addr_q  <= FIRST_READ;
						step_q  <= '0;
					end else if (accept && leaf_ok) begin
						state_q <= ST_ADD;
						addr_q  <= leaf_node;
					end
				end
				ST_ADD: begin
					if (addr_q == ROOT_NODE) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q >> 1;
					end
				end
				ST_QUERY: begin
					if (!last_step) begin
						addr_q <= next_addr;
						step_q <= step_q + wpbt_pkg::STEP_W'(1);
					end else if (finish_ok) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			left_q   <= budget;
			budget_q <= budget;
			cnt_q    <= '0;
			wadd_q   <= item_weight[wpbt_pkg::WIN_BITS-1:0];
		end else if (state_q == ST_QUERY && !last_step) begin
			left_q <= left_next;
			cnt_q  <= cnt_next;
		end
		if (state_q == ST_QUERY && last_step && finish_ok) begin
			fit_count_q  <= cnt_next;
			fit_weight_q <= budget_q - left_next;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign fit_count  = fit_count_q;
	assign fit_weight = fit_weight_q;

	`WPBT_ASSERT(a_rsp_from_query, $rose(rsp_valid_q) |-> $past(state_q == ST_QUERY), "result without a query")
	`WPBT_ASSERT_ON(a_fit_in_budget, $rose(rsp_valid_q), fit_weight_q <= budget_q, "fit weight exceeds budget")
	`WPBT_ASSERT_ON(a_no_idle_write, state_q == ST_IDLE, !ram_wr_en, "node write while idle")
	`WPBT_ASSERT_ON(a_add_walks_up, state_q == ST_ADD && addr_q != ROOT_NODE, ram_rd_addr == (addr_q >> 1), "add path does not read the parent")

endmodule
